// ----- design/rgb_hls_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB to HLS converter package
// Shared item types, hue base codes and fixed-point constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgb_hls_pkg;

  localparam logic [1:0] BASE_RED   = 2'd0;
  localparam logic [1:0] BASE_GREEN = 2'd1;
  localparam logic [1:0] BASE_BLUE  = 2'd2;

  localparam logic [13:0] HUE_FULL   = 14'd5760;
  localparam logic [13:0] HUE_GREEN  = 14'd1920;
  localparam logic [13:0] HUE_BLUE   = 14'd3840;
  localparam logic [12:0] L_BLACK    = 13'd410;
  localparam logic [12:0] L_WHITE    = 13'd4055;
  localparam logic [8:0]  SUM_WHITE  = 9'd510;
  localparam logic [8:0]  SUM_HALF   = 9'd255;

  localparam int SAT_STEPS = 13;
  localparam int HUE_STEPS = 10;

  typedef struct packed {
    logic       hv;
    logic [1:0] base;
    logic       neg;
    logic [8:0] sum;
    logic [7:0] spread;
    logic [7:0] q;
  } item_t;

  typedef struct packed {
    logic [12:0] hue;
    logic        hue_valid;
    logic [12:0] lightness;
    logic [12:0] saturation;
  } result_t;

endpackage

`default_nettype wire

// ----- design/rgb_to_hls_converter_unit.sv -----
// ----------------------------------------------------------------------------
// RGB to HLS converter unit
// Converts 8-bit RGB pixels to nonlinear hue, lightness and saturation.
//
//   channel  | handshake        | payload
//   ---------+------------------+--------------------------------------------
//   request  | push / full      | red, green, blue
//   result   | empty / pop      | hue, hue_valid, lightness, saturation
//
// One request per cycle sustained while full is low; each request passes
// through the mid queue between front and back end, the sa and sb stages
// and the 13-stage saturation divider pipeline. Reset clears both queues
// and all stage valid flags. A full result queue freezes the back end when
// its last stage holds a result; full rises once the mid queue has filled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hls_converter_unit
  import rgb_hls_pkg::*;
#(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  output logic             empty,
  input  wire logic        pop,
  output logic [12:0]      hue,
  output logic             hue_valid,
  output logic [12:0]      lightness,
  output logic [12:0]      saturation
);

  item_t   front_item;
  item_t   mid_item;
  logic    mid_empty;
  logic    mid_pop;
  logic    out_full;
  logic    out_push;
  result_t back_res;
  result_t out_res;

  rgb_hls_front u_front (
    .red   (red),
    .green (green),
    .blue  (blue),
    .item  (front_item)
  );

  rgb_hls_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_item),
    .full  (full),
    .pop   (mid_pop),
    .dout  (mid_item),
    .empty (mid_empty)
  );

  rgb_hls_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_item  (mid_item),
    .in_empty (mid_empty),
    .in_pop   (mid_pop),
    .out_full (out_full),
    .out_push (out_push),
    .out_res  (back_res)
  );

  rgb_hls_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (back_res),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_res),
    .empty (empty)
  );

  assign hue        = out_res.hue;
  assign hue_valid  = out_res.hue_valid;
  assign lightness  = out_res.lightness;
  assign saturation = out_res.saturation;

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("result written into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    mid_pop |-> !mid_empty)
    else $error("back end took from an empty queue");

  a_gray_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !hue_valid) |-> (hue == '0 && saturation == '0))
    else $error("gray pixel with nonzero hue or saturation");

  a_sat_nonzero: assert property (@(posedge clk) disable iff (rst)
    (!empty && hue_valid) |-> (saturation != '0 && hue < 13'd5760))
    else $error("chromatic pixel with zero saturation or hue out of range");

endmodule

`default_nettype wire

// ----- design/rgb_hls_fifo.sv -----
// ----------------------------------------------------------------------------
// RGB to HLS small queue
// Register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_hls_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/rgb_hls_front.sv -----
// ----------------------------------------------------------------------------
// RGB to HLS front end
// Sorts the pixel components, picks the dominant one and forms the hue term.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_hls_front
  import rgb_hls_pkg::*;
(
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  output item_t           item
);

  logic [7:0] mx;
  logic [7:0] mn;
  logic [7:0] hi;
  logic [7:0] lo;
  logic [1:0] base;

  always_comb begin
    mx = (red > green) ? red : green;
    mx = (mx > blue) ? mx : blue;
    mn = (red < green) ? red : green;
    mn = (mn < blue) ? mn : blue;
    if (red == mx) begin
      base = BASE_RED;
      hi   = green;
      lo   = blue;
    end else if (green == mx) begin
      base = BASE_GREEN;
      hi   = blue;
      lo   = red;
    end else begin
      base = BASE_BLUE;
      hi   = red;
      lo   = green;
    end
    item.hv     = (mx != mn);
    item.base   = base;
    item.neg    = (hi < lo);
    item.q      = (hi < lo) ? (lo - hi) : (hi - lo);
    item.sum    = {1'b0, mx} + {1'b0, mn};
    item.spread = mx - mn;
  end

endmodule

`default_nettype wire

// ----- design/rgb_hls_back.sv -----
// ----------------------------------------------------------------------------
// RGB to HLS back end
// Lightness, squares, then pipelined restoring dividers for saturation and
// hue, one quotient bit per stage; the whole pipe holds when the result
// queue is full and the last divider stage holds a result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_hls_back
  import rgb_hls_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire item_t in_item,
  input  wire logic  in_empty,
  output logic       in_pop,
  input  wire logic  out_full,
  output logic       out_push,
  output result_t    out_res
);

  typedef struct packed {
    logic        vld;
    logic        hv;
    logic [1:0]  base;
    logic        neg;
    logic [12:0] light;
    logic [7:0]  denom;
    logic [19:0] ns;
    logic [15:0] qsq;
    logic [15:0] sq;
  } sq_stage_t;

  typedef struct packed {
    logic        vld;
    logic        hv;
    logic [1:0]  base;
    logic        neg;
    logic [12:0] light;
    logic [7:0]  denom;
    logic [19:0] ns;
    logic [25:0] nh;
    logic [15:0] sq;
  } num_stage_t;

  typedef struct packed {
    logic        vld;
    logic        hv;
    logic [1:0]  base;
    logic        neg;
    logic [12:0] light;
    logic [7:0]  denom;
    logic [19:0] ns;
    logic [7:0]  rs;
    logic [12:0] qs;
    logic [25:0] nh;
    logic [15:0] sq;
    logic [15:0] rh;
    logic [9:0]  qh;
  } div_stage_t;

  sq_stage_t  sa;
  sq_stage_t  sa_next;
  num_stage_t sb;
  num_stage_t sb_next;
  div_stage_t dv      [SAT_STEPS];
  div_stage_t dv_next [SAT_STEPS];
  div_stage_t dv_src  [SAT_STEPS];
  logic       adv;

  assign adv      = !dv[SAT_STEPS-1].vld || !out_full;
  assign in_pop   = adv && !in_empty;
  assign out_push = dv[SAT_STEPS-1].vld && !out_full;

  // lightness, saturation numerator and the two squares
  logic [12:0] ly;
  logic [20:0] lp;
  logic [4:0]  lq0;
  logic [12:0] lr;
  logic [4:0]  lq;
  logic [8:0]  dfull;

  always_comb begin
    ly  = {1'b0, in_item.sum, 3'b000} + 13'd127;
    lp  = {ly, 8'h00} + {8'h00, ly};
    lq0 = lp[20:16];
    lr  = ly - ({lq0, 8'h00} - {8'h00, lq0});
    lq  = (lr >= 13'd255) ? lq0 + 5'd1 : lq0;
    dfull = (in_item.sum <= SUM_HALF) ? in_item.sum : SUM_WHITE - in_item.sum;

    sa_next.vld   = !in_empty;
    sa_next.hv    = in_item.hv;
    sa_next.base  = in_item.base;
    sa_next.neg   = in_item.neg;
    if (in_item.sum == '0) begin
      sa_next.light = L_BLACK;
    end else if (in_item.sum == SUM_WHITE) begin
      sa_next.light = L_WHITE;
    end else begin
      sa_next.light = {1'b0, in_item.sum, 3'b000} + {8'h00, lq};
    end
    sa_next.denom = dfull[7:0];
    sa_next.ns    = {in_item.spread, 12'h000} | {13'h0000, dfull[7:1]};
    sa_next.qsq   = in_item.q * in_item.q;
    sa_next.sq    = in_item.spread * in_item.spread;
  end

  // hue numerator: 960 * q^2 plus half the divisor
  always_comb begin
    sb_next.vld   = sa.vld;
    sb_next.hv    = sa.hv;
    sb_next.base  = sa.base;
    sb_next.neg   = sa.neg;
    sb_next.light = sa.light;
    sb_next.denom = sa.denom;
    sb_next.ns    = sa.ns;
    sb_next.sq    = sa.sq;
    sb_next.nh    = {sa.qsq, 10'h000} - {4'h0, sa.qsq, 6'h00} + {11'h000, sa.sq[15:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa.vld <= 1'b0;
      sb.vld <= 1'b0;
    end else if (adv) begin
      sa <= sa_next;
      sb <= sb_next;
    end
  end

  for (genvar j = 0; j < SAT_STEPS; j++) begin : g_div
    if (j == 0) begin : g_init
      always_comb begin
        dv_src[j].vld   = sb.vld;
        dv_src[j].hv    = sb.hv;
        dv_src[j].base  = sb.base;
        dv_src[j].neg   = sb.neg;
        dv_src[j].light = sb.light;
        dv_src[j].denom = sb.denom;
        dv_src[j].ns    = sb.ns;
        dv_src[j].rs    = {1'b0, sb.ns[19:13]};
        dv_src[j].qs    = '0;
        dv_src[j].nh    = sb.nh;
        dv_src[j].sq    = sb.sq;
        dv_src[j].rh    = sb.nh[25:10];
        dv_src[j].qh    = '0;
      end
    end else begin : g_link
      assign dv_src[j] = dv[j-1];
    end

    logic [8:0]  snb;
    logic [7:0]  rs_step;
    logic [12:0] qs_step;
    always_comb begin
      snb = {dv_src[j].rs, dv_src[j].ns[SAT_STEPS-1-j]};
      if (snb >= {1'b0, dv_src[j].denom}) begin
        rs_step = 8'(snb - {1'b0, dv_src[j].denom});
        qs_step = {dv_src[j].qs[11:0], 1'b1};
      end else begin
        rs_step = snb[7:0];
        qs_step = {dv_src[j].qs[11:0], 1'b0};
      end
    end

    if (j < HUE_STEPS) begin : g_hue
      logic [16:0] hnb;
      logic [15:0] rh_step;
      logic [9:0]  qh_step;
      always_comb begin
        hnb = {dv_src[j].rh, dv_src[j].nh[HUE_STEPS-1-j]};
        if (hnb >= {1'b0, dv_src[j].sq}) begin
          rh_step = 16'(hnb - {1'b0, dv_src[j].sq});
          qh_step = {dv_src[j].qh[8:0], 1'b1};
        end else begin
          rh_step = hnb[15:0];
          qh_step = {dv_src[j].qh[8:0], 1'b0};
        end
        dv_next[j]    = dv_src[j];
        dv_next[j].rs = rs_step;
        dv_next[j].qs = qs_step;
        dv_next[j].rh = rh_step;
        dv_next[j].qh = qh_step;
      end
    end else begin : g_sat_only
      always_comb begin
        dv_next[j]    = dv_src[j];
        dv_next[j].rs = rs_step;
        dv_next[j].qs = qs_step;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j].vld <= 1'b0;
      end else if (adv) begin
        dv[j] <= dv_next[j];
      end
    end
  end

  // place the hue term around its base and wrap into one turn
  div_stage_t  last;
  logic [13:0] base_hue;
  logic [13:0] mag;
  logic [13:0] hue_raw;
  logic [13:0] hue_wrap;

  assign last = dv[SAT_STEPS-1];

  always_comb begin
    unique case (last.base)
      BASE_RED:   base_hue = '0;
      BASE_GREEN: base_hue = HUE_GREEN;
      BASE_BLUE:  base_hue = HUE_BLUE;
      default:    base_hue = '0;
    endcase
    mag = {4'h0, last.qh};
    if (last.neg) begin
      hue_raw = (mag > base_hue) ? base_hue + HUE_FULL - mag : base_hue - mag;
    end else begin
      hue_raw = base_hue + mag;
    end
    hue_wrap = (hue_raw >= HUE_FULL) ? hue_raw - HUE_FULL : hue_raw;

    out_res.hue        = last.hv ? hue_wrap[12:0] : '0;
    out_res.hue_valid  = last.hv;
    out_res.lightness  = last.light;
    out_res.saturation = last.hv ? last.qs : '0;
  end

endmodule

`default_nettype wire
